// File: hw/rtl/tswp_pkg.sv
// Shared constants, types and helper functions of the token sliding-window pacer.
package tswp_pkg;

  localparam int MAX_ENTRIES = 64;

  localparam int CMD_W   = 2;
  localparam int TIME_W  = 40;
  localparam int TOK_W   = 20;
  localparam int WIN_W   = 22;
  localparam int ENTRY_W = TIME_W + TOK_W;
  localparam int PTR_W   = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W   = TOK_W + CNT_W;
  localparam int NEED_W  = SUM_W + 2;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [TOK_W-1:0] TPM_RESET = TOK_W'(1);
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(60000);

  localparam logic REG_TPM = 1'b0;
  localparam logic REG_WIN = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY    = 2'd0,
    CMD_RECORD   = 2'd1,
    CMD_ACTIVATE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    RD_OLDEST      = 2'd0,
    RD_OLDEST_NEXT = 2'd1,
    RD_WALK_NEXT   = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_FULL  = 2'd1,
    RES_DELAY = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     set_pacing;
    logic     record_wr;
    logic     pop;
    logic     start_walk;
    logic     step;
    logic     res_en;
    res_sel_t res_sel;
    rd_sel_t  rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             pacing;
    logic             empty;
    logic             full;
    logic             age_lt_win;
    logic             last_live;
    logic             need_le0;
    logic             tok_ge_need;
    logic             last_remain;
  } dp_stat_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PTR_W'(MAX_ENTRIES - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_add(ptr_t p, cnt_t c);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(p) + (CNT_W + 1)'(c);
    if (s >= (CNT_W + 1)'(MAX_ENTRIES)) begin
      s = s - (CNT_W + 1)'(MAX_ENTRIES);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// File: hw/rtl/tswp_if.sv
// Valid/ready stream interfaces for the request and result channels.
interface tswp_in_if import tswp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [TIME_W-1:0] timestamp_ms;
  logic [TOK_W-1:0]  tokens;

  modport source (output valid, command, timestamp_ms, tokens, input ready);
  modport sink   (input valid, command, timestamp_ms, tokens, output ready);
endinterface

interface tswp_out_if import tswp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] delay_ms;
  logic             table_full;

  modport source (output valid, delay_ms, table_full, input ready);
  modport sink   (input valid, delay_ms, table_full, output ready);
endinterface

// File: hw/rtl/tswp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tswp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tswp_cfg.sv
// APB register file holding the token budget and the window length.
module tswp_cfg import tswp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [TOK_W-1:0]  tpm,
  output logic [WIN_W-1:0]  win
);

  logic [TOK_W-1:0] tpm_r, tpm_nxt;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic             reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    tpm_nxt = tpm_r;
    win_nxt = win_r;
    if (wr_en) begin
      if (reg_idx == REG_TPM) begin
        tpm_nxt = pwdata[TOK_W-1:0];
      end else begin
        win_nxt = pwdata[WIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r <= TPM_RESET;
      win_r <= WIN_RESET;
    end else begin
      tpm_r <= tpm_nxt;
      win_r <= win_nxt;
    end
  end

  assign prdata = (reg_idx == REG_WIN) ? APB_DW'(win_r) : APB_DW'(tpm_r);
  assign tpm    = tpm_r;
  assign win    = win_r;

endmodule

// File: hw/rtl/tswp_ctrl.sv
// Controller state machine that sequences decode, pruning and the budget walk.
module tswp_ctrl import tswp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t dp_stat,
  output dp_cmd_t  dp_cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_PRUNE  = 6'b000100,
    S_NEED   = 6'b001000,
    S_WALK   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    dp_cmd         = '0;
    dp_cmd.rd_sel  = RD_OLDEST;
    dp_cmd.res_sel = RES_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load_item = 1'b1;
          state_nxt        = S_DECODE;
        end
      end
      S_DECODE: begin
        dp_cmd.res_en = 1'b1;
        state_nxt     = S_RESP;
        if (dp_stat.command == CMD_ACTIVATE) begin
          dp_cmd.set_pacing = 1'b1;
        end else if (dp_stat.command == CMD_RECORD) begin
          if (dp_stat.full) begin
            dp_cmd.res_sel = RES_FULL;
          end else begin
            dp_cmd.record_wr = 1'b1;
          end
        end else if (dp_stat.command == CMD_QUERY && dp_stat.pacing && !dp_stat.empty) begin
          dp_cmd.res_en = 1'b0;
          state_nxt     = S_PRUNE;
        end
      end
      S_PRUNE: begin
        dp_cmd.rd_sel = RD_OLDEST_NEXT;
        if (!dp_stat.age_lt_win) begin
          dp_cmd.pop = 1'b1;
          if (dp_stat.last_live) begin
            dp_cmd.res_en = 1'b1;
            state_nxt     = S_RESP;
          end
        end else begin
          state_nxt = S_NEED;
        end
      end
      S_NEED: begin
        dp_cmd.start_walk = 1'b1;
        state_nxt         = S_WALK;
      end
      S_WALK: begin
        dp_cmd.rd_sel = RD_WALK_NEXT;
        if (dp_stat.need_le0) begin
          dp_cmd.res_en = 1'b1;
          state_nxt     = S_RESP;
        end else if (dp_stat.tok_ge_need) begin
          dp_cmd.res_en  = 1'b1;
          dp_cmd.res_sel = RES_DELAY;
          state_nxt      = S_RESP;
        end else begin
          dp_cmd.step = 1'b1;
          if (dp_stat.last_remain) begin
            dp_cmd.res_en = 1'b1;
            state_nxt     = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("Input and result handshakes are open at the same time.");

  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second transaction was admitted while one is in progress.");

endmodule

// File: hw/rtl/tswp_dp.sv
// Datapath with the ring pointers, running token sum, walk registers and result.
module tswp_dp import tswp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            dp_cmd,
  output dp_stat_t           dp_stat,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [TIME_W-1:0]  in_timestamp_ms,
  input  logic [TOK_W-1:0]   in_tokens,
  input  logic [TOK_W-1:0]   tpm,
  input  logic [WIN_W-1:0]   win,
  output logic               ram_we,
  output ptr_t               ram_waddr,
  output logic [ENTRY_W-1:0] ram_wdata,
  output ptr_t               ram_raddr,
  input  logic [ENTRY_W-1:0] ram_rdata,
  output logic [WIN_W-1:0]   delay_ms,
  output logic               table_full
);

  ptr_t                     oldest_r, oldest_nxt;
  cnt_t                     count_r, count_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic                     pacing_r, pacing_nxt;
  ptr_t                     walk_r, walk_nxt;
  cnt_t                     remain_r, remain_nxt;
  logic signed [NEED_W-1:0] need_r, need_nxt;
  logic [CMD_W-1:0]         command_r, command_nxt;
  logic [TIME_W-1:0]        now_r, now_nxt;
  logic [TOK_W-1:0]         tok_r, tok_nxt;
  logic [WIN_W-1:0]         delay_r, delay_nxt;
  logic                     full_r, full_nxt;

  logic [TIME_W-1:0]        rd_time;
  logic [TOK_W-1:0]         rd_tok;
  logic [TIME_W:0]          time_diff;
  logic [TIME_W-1:0]        age;
  logic                     age_lt_win;
  logic [WIN_W-1:0]         win_minus_age;
  logic [TOK_W-1:0]         limit;
  logic signed [NEED_W-1:0] need_calc;
  logic signed [NEED_W-1:0] tok_ext;

  assign rd_time       = ram_rdata[ENTRY_W-1:TOK_W];
  assign rd_tok        = ram_rdata[TOK_W-1:0];
  assign time_diff     = {1'b0, now_r} - {1'b0, rd_time};
  assign age           = time_diff[TIME_W] ? '0 : time_diff[TIME_W-1:0];
  assign age_lt_win    = (age[TIME_W-1:WIN_W] == '0) && (age[WIN_W-1:0] < win);
  assign win_minus_age = win - age[WIN_W-1:0];
  assign limit         = (tpm == '0) ? TOK_W'(1) : tpm;
  assign need_calc     = $signed({2'b00, sum_r}) + $signed(NEED_W'(tok_r))
                         - $signed(NEED_W'(limit));
  assign tok_ext       = $signed(NEED_W'(rd_tok));

  always_comb begin
    oldest_nxt  = oldest_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    pacing_nxt  = pacing_r;
    walk_nxt    = walk_r;
    remain_nxt  = remain_r;
    need_nxt    = need_r;
    command_nxt = command_r;
    now_nxt     = now_r;
    tok_nxt     = tok_r;
    delay_nxt   = delay_r;
    full_nxt    = full_r;
    if (dp_cmd.load_item) begin
      command_nxt = in_command;
      now_nxt     = in_timestamp_ms;
      tok_nxt     = in_tokens;
    end
    if (dp_cmd.set_pacing) begin
      pacing_nxt = 1'b1;
    end
    if (dp_cmd.record_wr) begin
      count_nxt = count_r + cnt_t'(1);
      sum_nxt   = sum_r + SUM_W'(tok_r);
    end
    if (dp_cmd.pop) begin
      oldest_nxt = ptr_inc(oldest_r);
      count_nxt  = count_r - cnt_t'(1);
      sum_nxt    = sum_r - SUM_W'(rd_tok);
    end
    if (dp_cmd.start_walk) begin
      walk_nxt   = oldest_r;
      remain_nxt = count_r;
      need_nxt   = need_calc;
    end
    if (dp_cmd.step) begin
      walk_nxt   = ptr_inc(walk_r);
      remain_nxt = remain_r - cnt_t'(1);
      need_nxt   = need_r - tok_ext;
    end
    if (dp_cmd.res_en) begin
      unique case (dp_cmd.res_sel)
        RES_FULL: begin
          delay_nxt = '0;
          full_nxt  = 1'b1;
        end
        RES_DELAY: begin
          delay_nxt = age_lt_win ? win_minus_age : '0;
          full_nxt  = 1'b0;
        end
        default: begin
          delay_nxt = '0;
          full_nxt  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      sum_r    <= '0;
      pacing_r <= 1'b0;
    end else begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      pacing_r <= pacing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r    <= walk_nxt;
    remain_r  <= remain_nxt;
    need_r    <= need_nxt;
    command_r <= command_nxt;
    now_r     <= now_nxt;
    tok_r     <= tok_nxt;
    delay_r   <= delay_nxt;
    full_r    <= full_nxt;
  end

  always_comb begin
    unique case (dp_cmd.rd_sel)
      RD_OLDEST_NEXT: ram_raddr = ptr_inc(oldest_r);
      RD_WALK_NEXT:   ram_raddr = ptr_inc(walk_r);
      default:        ram_raddr = oldest_r;
    endcase
  end

  assign ram_we    = dp_cmd.record_wr;
  assign ram_waddr = ptr_add(oldest_r, count_r);
  assign ram_wdata = {now_r, tok_r};

  assign dp_stat.command     = command_r;
  assign dp_stat.pacing      = pacing_r;
  assign dp_stat.empty       = (count_r == '0);
  assign dp_stat.full        = (count_r == CNT_W'(MAX_ENTRIES));
  assign dp_stat.age_lt_win  = age_lt_win;
  assign dp_stat.last_live   = (count_r == cnt_t'(1));
  assign dp_stat.need_le0    = need_r[NEED_W-1] || (need_r == '0);
  assign dp_stat.tok_ge_need = (tok_ext >= need_r);
  assign dp_stat.last_remain = (remain_r == cnt_t'(1));

  assign delay_ms   = delay_r;
  assign table_full = full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("Live entry count exceeds the ring depth.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.pop |-> (count_r != '0))
    else $error("An entry was pruned from an empty ring.");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (sum_r == '0))
    else $error("Running token sum is nonzero with no live entries.");

endmodule

// File: hw/rtl/token_sliding_window_pacer.sv
// Top level of the token sliding-window pacer: controller, datapath, entry RAM, registers.
// Activate, record and other commands pass from acceptance through S_DECODE to S_RESP.
// A query may also pass through S_PRUNE, S_NEED and S_WALK before S_RESP; one entry is read per
// cycle, first while pruning expired entries and then while walking the live ones.
// One transaction is in progress at a time; the next is taken the cycle after the result is.
// Reset (rst_n, synchronous, active low) empties the ring, turns pacing off and restores a
// budget of 1 token and a 60000 ms window; the entry RAM is not cleared.
module token_sliding_window_pacer import tswp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tswp_in_if.sink           in_if,
  tswp_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  dp_cmd_t            dp_cmd;
  dp_stat_t           dp_stat;
  logic [TOK_W-1:0]   tpm;
  logic [WIN_W-1:0]   win;
  logic               ram_we;
  ptr_t               ram_waddr;
  ptr_t               ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  tswp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tpm     (tpm),
    .win     (win)
  );

  tswp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  tswp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .dp_cmd          (dp_cmd),
    .dp_stat         (dp_stat),
    .in_command      (in_if.command),
    .in_timestamp_ms (in_if.timestamp_ms),
    .in_tokens       (in_if.tokens),
    .tpm             (tpm),
    .win             (win),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .delay_ms        (out_if.delay_ms),
    .table_full      (out_if.table_full)
  );

  tswp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: tb/token_sliding_window_pacer_tb.sv
// Self-checking testbench for the token sliding-window pacer with scoreboard, drivers and watchdog.
module token_sliding_window_pacer_tb;
  import tswp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam logic [TIME_W-1:0] TIME_TOP = '1;
  localparam logic [TOK_W-1:0] TOK_TOP = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] stamp;
    logic [TOK_W-1:0]  tokens;
  } request_t;

  typedef struct packed {
    logic [WIN_W-1:0] delay_ms;
    logic             table_full;
  } reply_t;

  typedef struct {
    logic [TOK_W-1:0] budget;
    logic [WIN_W-1:0] window;
    int unsigned      step;
    int unsigned      tok_span;
    int unsigned      count;
    bit               idle;
  } phase_t;

  class pacer_scoreboard;
    logic [TIME_W-1:0] slot_time [MAX_ENTRIES];
    logic [TOK_W-1:0]  slot_tokens [MAX_ENTRIES];
    int unsigned       head;
    int unsigned       live;
    bit                pacing;
    logic [TOK_W-1:0]  budget;
    logic [WIN_W-1:0]  window;
    reply_t            due_replies[$];
    int unsigned       errors;
    int unsigned       accepted;
    int unsigned       paced;
    int unsigned       dropped;

    function new();
      head = 0;
      live = 0;
      pacing = 1'b0;
      budget = TPM_RESET;
      window = WIN_RESET;
      errors = 0;
      accepted = 0;
      paced = 0;
      dropped = 0;
    endfunction

    function void set_register(logic idx, logic [APB_DW-1:0] value);
      if (idx == REG_TPM) begin
        budget = value[TOK_W-1:0];
      end else begin
        window = value[WIN_W-1:0];
      end
    endfunction

    function longint unsigned age_at(logic [TIME_W-1:0] now, int unsigned s);
      return (now >= slot_time[s]) ? longint'(now - slot_time[s]) : 0;
    endfunction

    function logic [WIN_W-1:0] wait_for(logic [TIME_W-1:0] now, logic [TOK_W-1:0] tok);
      longint used;
      longint need;
      longint lim;
      longint unsigned age;
      int unsigned s;
      if (!pacing) begin
        return '0;
      end
      while (live > 0 && age_at(now, head) >= longint'(window)) begin
        head = (head + 1) % MAX_ENTRIES;
        live--;
      end
      used = 0;
      for (int unsigned k = 0; k < live; k++) begin
        used += longint'(slot_tokens[(head + k) % MAX_ENTRIES]);
      end
      lim = (budget == '0) ? 1 : longint'(budget);
      need = longint'(tok) + used - lim;
      for (int unsigned k = 0; k < live; k++) begin
        s = (head + k) % MAX_ENTRIES;
        if (need <= 0) begin
          break;
        end
        if (longint'(slot_tokens[s]) >= need) begin
          age = age_at(now, s);
          if (age < longint'(window)) begin
            return WIN_W'(longint'(window) - age);
          end
          return '0;
        end
        need -= longint'(slot_tokens[s]);
      end
      return '0;
    endfunction

    function void note_request(request_t r);
      reply_t rep;
      int unsigned s;
      rep = '0;
      case (r.command)
        CMD_QUERY: begin
          rep.delay_ms = wait_for(r.stamp, r.tokens);
        end
        CMD_RECORD: begin
          if (live >= MAX_ENTRIES) begin
            rep.table_full = 1'b1;
          end else begin
            s = (head + live) % MAX_ENTRIES;
            slot_time[s] = r.stamp;
            slot_tokens[s] = r.tokens;
            live++;
          end
        end
        CMD_ACTIVATE: begin
          pacing = 1'b1;
        end
        default: begin
        end
      endcase
      accepted++;
      if (rep.delay_ms != '0) begin
        paced++;
      end
      if (rep.table_full) begin
        dropped++;
      end
      due_replies.push_back(rep);
    endfunction

    function void check_result(logic [WIN_W-1:0] delay_ms, logic table_full);
      reply_t exp;
      if (due_replies.size() == 0) begin
        $error("Unexpected result: delay_ms=%0d table_full=%0b", delay_ms, table_full);
        errors++;
        return;
      end
      exp = due_replies.pop_front();
      if (delay_ms !== exp.delay_ms) begin
        $error("Field delay_ms: expected %0d, actual %0d", exp.delay_ms, delay_ms);
        errors++;
      end
      if (table_full !== exp.table_full) begin
        $error("Field table_full: expected %0b, actual %0b", exp.table_full, table_full);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_replies.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  tswp_in_if in_if ();
  tswp_out_if out_if ();

  token_sliding_window_pacer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  pacer_scoreboard sb = new();
  bit stalls_on = 1'b1;
  int unsigned quiet_cycles = 0;
  int unsigned settings_used = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.delay_ms, out_if.table_full);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic request_t make_req(logic [CMD_W-1:0] c, logic [TIME_W-1:0] t,
                                        logic [TOK_W-1:0] n);
    request_t r;
    r.command = c;
    r.stamp = t;
    r.tokens = n;
    return r;
  endfunction

  task automatic send_request(input request_t r, input bit allow_idle);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.command <= r.command;
    in_if.timestamp_ms <= r.stamp;
    in_if.tokens <= r.tokens;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    send_request(make_req(CMD_QUERY, '0, TOK_TOP), 1'b1);
    send_request(make_req(CMD_RECORD, '0, '0), 1'b1);
    send_request(make_req(CMD_UNUSED, TIME_TOP, TOK_TOP), 1'b1);
    send_request(make_req(CMD_ACTIVATE, 40'd5, '0), 1'b1);
    send_request(make_req(CMD_RECORD, 40'd10, 20'd1), 1'b1);
    send_request(make_req(CMD_QUERY, 40'd20, 20'd1), 1'b1);
    send_request(make_req(CMD_QUERY, 40'd20, 20'd2), 1'b1);
    send_request(make_req(CMD_QUERY, 40'd20, '0), 1'b1);
    send_request(make_req(CMD_RECORD, 40'd60000, TOK_TOP), 1'b1);
    send_request(make_req(CMD_QUERY, 40'd60000, 20'd1), 1'b1);
    send_request(make_req(CMD_QUERY, 40'd30, 20'd1), 1'b1);
    send_request(make_req(CMD_RECORD, TIME_TOP, 20'h55555), 1'b1);
    send_request(make_req(CMD_RECORD, TIME_TOP, 20'hAAAAA), 1'b1);
    send_request(make_req(CMD_QUERY, TIME_TOP, 20'd1), 1'b1);
    send_request(make_req(CMD_QUERY, TIME_TOP, TOK_TOP), 1'b1);
    send_request(make_req(CMD_UNUSED, '0, '0), 1'b1);
    send_request(make_req(CMD_ACTIVATE, TIME_TOP, TOK_TOP), 1'b1);
  endtask

  task automatic run_phase(input phase_t p, input bit hold_midway);
    request_t r;
    int unsigned pick;
    int unsigned back;
    drain();
    @(negedge clk);
    apb_write(REG_TPM, APB_DW'(p.budget));
    @(negedge clk);
    apb_write(REG_WIN, APB_DW'(p.window));
    settings_used++;
    stalls_on = p.idle;
    for (int unsigned i = 0; i < p.count; i++) begin
      if (hold_midway && i == p.count / 2) begin
        in_if.valid <= 1'b0;
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 44) begin
        r.command = CMD_QUERY;
      end else if (pick < 91) begin
        r.command = CMD_RECORD;
      end else if (pick < 96) begin
        r.command = CMD_ACTIVATE;
      end else begin
        r.command = CMD_UNUSED;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        clock_ms += TIME_W'(p.window) + TIME_W'($urandom_range(0, 1000));
        r.stamp = clock_ms;
      end else if (pick < 6) begin
        back = $urandom_range(0, int'(p.window) + 10);
        r.stamp = (clock_ms > TIME_W'(back)) ? clock_ms - TIME_W'(back) : '0;
      end else begin
        clock_ms += TIME_W'($urandom_range(0, p.step));
        r.stamp = clock_ms;
      end
      if ($urandom_range(0, 19) == 0) begin
        r.tokens = TOK_W'($urandom_range(0, int'(TOK_TOP)));
      end else begin
        r.tokens = TOK_W'($urandom_range(0, p.tok_span));
      end
      send_request(r, p.idle);
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    phase_t plan [6];
    int unsigned tpm_pick;
    int unsigned win_pick;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.command <= CMD_QUERY;
    in_if.timestamp_ms <= '0;
    in_if.tokens <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    tpm_pick = $urandom_range(1, 5000);
    win_pick = $urandom_range(50, 3000);
    plan[0] = '{budget: '0, window: '0, step: 5, tok_span: 4, count: 150, idle: 1'b1};
    plan[1] = '{budget: 20'd1000, window: 22'd1000, step: 40, tok_span: 400, count: 350,
                idle: 1'b1};
    plan[2] = '{budget: TOK_TOP, window: '1, step: 3, tok_span: int'(TOK_TOP), count: 250,
                idle: 1'b1};
    plan[3] = '{budget: 20'd1, window: 22'd1, step: 1, tok_span: 2, count: 200, idle: 1'b1};
    plan[4] = '{budget: TOK_W'(tpm_pick), window: WIN_W'(win_pick), step: win_pick / 20 + 1,
                tok_span: tpm_pick / 3 + 1, count: 350, idle: 1'b1};
    plan[5] = '{budget: 20'd3000, window: 22'd600, step: 20, tok_span: 1000, count: 350,
                idle: 1'b0};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    in_if.valid <= 1'b0;
    clock_ms = 40'd1000;
    for (int i = 0; i < 6; i++) begin
      run_phase(plan[i], i == 1);
    end

    drain();
    repeat (80) @(posedge clk);
    $display("Covered %0d transactions under %0d register settings plus reset defaults.",
             sb.accepted, settings_used);
    $display("Of these, %0d queries were paced and %0d records were dropped on a full ring.",
             sb.paced, sb.dropped);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (sb.pending() != 0) begin
        $error("%0d expected results never arrived", sb.pending());
      end
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
